>>> rtl/bloom_filter_string_membership_core_macros.svh
// Assertion macros used by the Bloom filter back end (bfsm_back).
`ifndef BLOOM_FILTER_STRING_MEMBERSHIP_CORE_MACROS_SVH
`define BLOOM_FILTER_STRING_MEMBERSHIP_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk and switched off during reset.
`define BFSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and switched off during reset.
`define BFSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bfsm_pkg.sv
// Package with the types, constants and codes of the Bloom filter core.
`default_nettype none

package bfsm_pkg;

    localparam int BIT_COUNT_DEFAULT = 65536;
    localparam int NUM_SEEDS         = 5;
    localparam int NUM_HASH          = 2 * NUM_SEEDS;
    localparam int HASH_W            = 32;
    localparam int LEN_W             = 16;
    // Ten lanes issued one per cycle, then steps that drain the product and partial-remainder registers.
    localparam int REDUCE_STEPS      = NUM_HASH + 2;
    localparam int STEP_W            = $clog2(REDUCE_STEPS);
    localparam int PROBE_W           = $clog2(NUM_HASH);
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [HASH_W-1:0] POLY_MASK  = 32'h7FFF_FFFF;
    localparam logic [LEN_W-1:0]  LEN_MAX    = 16'd65535;
    localparam int                SHIFT_BITS = 5;

    // Seed i sits at index i.
    localparam logic [NUM_SEEDS-1:0][HASH_W-1:0] SEED_TABLE = {
        32'd131313, 32'd13131, 32'd1313, 32'd131, 32'd13
    };

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // One finished key: hash 2i is the masked polynomial hash of seed i,
    // hash 2i+1 the shift-add hash of seed i.
    typedef struct packed {
        op_t                              op;
        logic [LEN_W-1:0]                 len;
        logic [NUM_HASH-1:0][HASH_W-1:0]  hash;
    } job_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_REDUCE,
        BK_PROBE,
        BK_DRAIN,
        BK_RESULT
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/bfsm_queue.sv
// Small job queue between the hashing front end and the probing back end.
`default_nettype none

module bfsm_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire bfsm_pkg::job_t push_job,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output bfsm_pkg::job_t     pop_job
);
    import bfsm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bfsm_front.sv
// Front end: takes character transactions and keeps the ten running hashes.
`default_nettype none

module bfsm_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         hold,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_opcode,
    input  wire logic [bfsm_pkg::HASH_W-1:0]  s_character,
    input  wire logic                         s_has_char,
    input  wire logic                         s_key_last,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output bfsm_pkg::job_t                    push_job
);
    import bfsm_pkg::*;

    logic [HASH_W-1:0] poly_reg  [NUM_SEEDS];
    logic [HASH_W-1:0] poly_next [NUM_SEEDS];
    logic [HASH_W-1:0] poly_upd  [NUM_SEEDS];
    logic [HASH_W-1:0] shift_reg  [NUM_SEEDS];
    logic [HASH_W-1:0] shift_next [NUM_SEEDS];
    logic [HASH_W-1:0] shift_upd  [NUM_SEEDS];
    logic [LEN_W-1:0]  len_reg, len_next, len_upd;
    logic              accept;

    // A plain character needs no queue space; only the closing item does.
    assign s_ready    = !hold && (push_ready || !s_key_last);
    assign push_valid = s_valid && s_key_last && !hold;
    assign accept     = s_valid && s_ready;

    always_comb begin
        for (int i = 0; i < NUM_SEEDS; i++) begin
            if (s_has_char) begin
                poly_upd[i]  = poly_reg[i] * SEED_TABLE[i] + s_character;
                shift_upd[i] = (shift_reg[i] << SHIFT_BITS) + shift_reg[i] + s_character;
            end else begin
                poly_upd[i]  = poly_reg[i];
                shift_upd[i] = shift_reg[i];
            end
        end
        len_upd = (s_has_char && (len_reg != LEN_MAX)) ? len_reg + 1'b1 : len_reg;

        push_job.op  = op_t'(s_opcode);
        push_job.len = len_upd;
        for (int i = 0; i < NUM_SEEDS; i++) begin
            push_job.hash[2*i]     = poly_upd[i] & POLY_MASK;
            push_job.hash[2*i + 1] = shift_upd[i];
        end

        for (int i = 0; i < NUM_SEEDS; i++) begin
            poly_next[i]  = poly_reg[i];
            shift_next[i] = shift_reg[i];
        end
        len_next = len_reg;
        if (accept) begin
            if (s_key_last) begin
                for (int i = 0; i < NUM_SEEDS; i++) begin
                    poly_next[i]  = '0;
                    shift_next[i] = SEED_TABLE[i];
                end
                len_next = '0;
            end else begin
                for (int i = 0; i < NUM_SEEDS; i++) begin
                    poly_next[i]  = poly_upd[i];
                    shift_next[i] = shift_upd[i];
                end
                len_next = len_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SEEDS; i++) begin
                poly_reg[i]  <= '0;
                shift_reg[i] <= SEED_TABLE[i];
            end
            len_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_SEEDS; i++) begin
                poly_reg[i]  <= poly_next[i];
                shift_reg[i] <= shift_next[i];
            end
            len_reg <= len_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bfsm_back.sv
// Back end: reduces the hashes to bit indices and sets or tests the bit store.
`default_nettype none

`include "bloom_filter_string_membership_core_macros.svh"

module bfsm_back #(
    parameter int BIT_COUNT = bfsm_pkg::BIT_COUNT_DEFAULT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    output logic                clearing,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire bfsm_pkg::job_t pop_job,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic                m_present
);
    import bfsm_pkg::*;

    localparam int             IDX_W     = $clog2(BIT_COUNT);
    localparam logic [IDX_W:0] MODULUS   = (IDX_W + 1)'(BIT_COUNT);
    // The reciprocal of the bit count is scaled so that it just fits the hash
    // width; the estimated quotient is then low by at most one.
    localparam int             RED_SHIFT = HASH_W + IDX_W - 1;
    localparam int             QUO_W     = 2 * HASH_W - RED_SHIFT;
    localparam logic [2*HASH_W-1:0] RECIP_FULL =
        ((2*HASH_W)'(1) << RED_SHIFT) / (2*HASH_W)'(BIT_COUNT);
    localparam logic [HASH_W-1:0]   RECIP = RECIP_FULL[HASH_W-1:0];

    logic bit_mem [BIT_COUNT];

    back_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [PROBE_W-1:0] probe_reg, probe_next;
    logic               hit_reg, hit_next;
    logic               rd_pending_reg, rd_pending_next;
    logic               rd_data_reg;
    logic [LEN_W-1:0]   shortest_reg, shortest_next;
    logic [LEN_W-1:0]   longest_reg, longest_next;

    op_t                 op_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [HASH_W-1:0]   dvd_reg [NUM_HASH];
    logic                mul_valid_reg;
    logic [2*HASH_W-1:0] prod_reg;
    logic [HASH_W-1:0]   mul_dvd_reg;
    logic                sub_valid_reg;
    logic [IDX_W:0]      part_reg;
    logic [QUO_W-1:0]    quo;
    logic [HASH_W-1:0]   quo_mul;
    logic [IDX_W:0]      part_next;
    logic [IDX_W-1:0]    rem_fold;
    logic [IDX_W-1:0]    rem_reg [NUM_HASH];

    logic               load, issue;
    logic               mem_we, mem_wdata;
    logic [IDX_W-1:0]   mem_addr;

    // Three-stage remainder pipeline shared by all ten lanes: multiply by the
    // reciprocal, subtract the quotient times the bit count, then subtract the
    // bit count once more if the partial remainder still reaches it.
    always_comb begin
        quo       = prod_reg[2*HASH_W-1:RED_SHIFT];
        quo_mul   = HASH_W'(quo) * HASH_W'(BIT_COUNT);
        part_next = (IDX_W + 1)'(mul_dvd_reg - quo_mul);
        if (part_reg >= MODULUS) begin
            rem_fold = IDX_W'(part_reg - MODULUS);
        end else begin
            rem_fold = part_reg[IDX_W-1:0];
        end
    end

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        step_next       = step_reg;
        probe_next      = probe_reg;
        shortest_next   = shortest_reg;
        longest_next    = longest_reg;
        hit_next        = rd_pending_reg ? (hit_reg & rd_data_reg) : hit_reg;
        rd_pending_next = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = 1'b0;
        mem_addr        = rem_reg[probe_reg];
        pop_ready       = 1'b0;
        load            = 1'b0;
        issue           = 1'b0;
        m_valid         = 1'b0;

        unique case (state_reg)
            BK_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_addr_reg;
                if (clr_addr_reg == IDX_W'(BIT_COUNT - 1)) begin
                    state_next = BK_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            BK_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    load       = 1'b1;
                    hit_next   = (pop_job.len >= shortest_reg) && (pop_job.len <= longest_reg);
                    step_next  = '0;
                    state_next = BK_REDUCE;
                end
            end
            BK_REDUCE: begin
                issue     = (step_reg < STEP_W'(NUM_HASH));
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(REDUCE_STEPS - 1)) begin
                    probe_next = '0;
                    state_next = BK_PROBE;
                end
            end
            BK_PROBE: begin
                if (op_reg == OP_ADD) begin
                    mem_we    = 1'b1;
                    mem_wdata = 1'b1;
                end else begin
                    rd_pending_next = 1'b1;
                end
                if (probe_reg == PROBE_W'(NUM_HASH - 1)) begin
                    if (op_reg == OP_ADD) begin
                        if (len_reg < shortest_reg) begin
                            shortest_next = len_reg;
                        end
                        if (len_reg > longest_reg) begin
                            longest_next = len_reg;
                        end
                        state_next = BK_IDLE;
                    end else begin
                        state_next = BK_DRAIN;
                    end
                end else begin
                    probe_next = probe_reg + 1'b1;
                end
            end
            BK_DRAIN: begin
                state_next = BK_RESULT;
            end
            BK_RESULT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    assign clearing  = (state_reg == BK_CLEAR);
    assign m_present = hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_CLEAR;
            clr_addr_reg   <= '0;
            step_reg       <= '0;
            probe_reg      <= '0;
            hit_reg        <= 1'b0;
            rd_pending_reg <= 1'b0;
            shortest_reg   <= LEN_MAX;
            longest_reg    <= '0;
            mul_valid_reg  <= 1'b0;
            sub_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            step_reg       <= step_next;
            probe_reg      <= probe_next;
            hit_reg        <= hit_next;
            rd_pending_reg <= rd_pending_next;
            shortest_reg   <= shortest_next;
            longest_reg    <= longest_next;
            mul_valid_reg  <= issue;
            sub_valid_reg  <= mul_valid_reg;
        end
    end

    // The dividends move down one lane per issue, so lane 0 always feeds the
    // pipeline; the remainders enter at the top and end up in lane order.
    always_ff @(posedge aclk) begin
        if (load) begin
            op_reg  <= pop_job.op;
            len_reg <= pop_job.len;
            for (int i = 0; i < NUM_HASH; i++) begin
                dvd_reg[i] <= pop_job.hash[i];
            end
        end else if (issue) begin
            for (int i = 0; i < NUM_HASH - 1; i++) begin
                dvd_reg[i] <= dvd_reg[i + 1];
            end
        end
        if (issue) begin
            prod_reg    <= (2*HASH_W)'(dvd_reg[0]) * (2*HASH_W)'(RECIP);
            mul_dvd_reg <= dvd_reg[0];
        end
        if (mul_valid_reg) begin
            part_reg <= part_next;
        end
        if (sub_valid_reg) begin
            for (int i = 0; i < NUM_HASH - 1; i++) begin
                rem_reg[i] <= rem_reg[i + 1];
            end
            rem_reg[NUM_HASH-1] <= rem_fold;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bit_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= bit_mem[mem_addr];
    end

    `BFSM_ASSERT_IMP(a_result_only_for_query, state_reg == BK_RESULT,
                     op_reg == OP_QUERY, "result raised for an add")
    `BFSM_ASSERT_IMP(a_probe_within_store, state_reg == BK_PROBE,
                     (IDX_W + 1)'(rem_reg[probe_reg]) < MODULUS, "bit index beyond the store")
    `BFSM_ASSERT_IMP(a_quiet_while_clearing, state_reg == BK_CLEAR,
                     !pop_ready && !m_valid, "queue or result active during clearing")
    `BFSM_ASSERT_NEXT(a_range_stays_ordered, shortest_reg <= longest_reg,
                      shortest_reg <= longest_reg, "length range lost its order")

endmodule

`default_nettype wire

>>> rtl/bloom_filter_string_membership_core.sv
// Bloom filter core: a key streams in one character per transaction, a query answers membership.
// Throughput: one character transaction per cycle while not clearing; a key end also needs queue room.
// For each job the back end pops it, reduces the ten hashes and probes the ten bits; a query then
// drains its last read and waits on m_ready, so short keys are paced through the two-entry job queue.
// A query's answer passes the job queue and the back end's pop, reduce, probe and drain states.
// Reset: synchronous on aresetn low; then the bit store is cleared in full, with s_ready low meanwhile.
`default_nettype none

module bloom_filter_string_membership_core #(
    parameter int BIT_COUNT = bfsm_pkg::BIT_COUNT_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_opcode,
    input  wire logic [bfsm_pkg::HASH_W-1:0]  s_character,
    input  wire logic                         s_has_char,
    input  wire logic                         s_key_last,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_present
);
    import bfsm_pkg::*;

    // The front end folds every character into five polynomial and five
    // shift-add hashes and counts the key length. On the closing transaction
    // of a key it hands the finished hashes, the length and the opcode to the
    // job queue and restarts its accumulators, so the next key can stream in
    // at once.
    //
    // The back end pops one job at a time. It feeds the ten hashes one per
    // cycle through a pipelined reciprocal multiplier that reduces them modulo
    // the bit count, and then walks the ten indices through the single-port
    // bit store: an add sets the bits and widens the stored length range, a
    // query reads them and presents the answer in an output register until it
    // is taken.

    logic  clearing;
    logic  push_valid, push_ready;
    job_t  push_job;
    logic  pop_valid, pop_ready;
    job_t  pop_job;

    bfsm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hold        (clearing),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_character (s_character),
        .s_has_char  (s_has_char),
        .s_key_last  (s_key_last),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    bfsm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    bfsm_back #(
        .BIT_COUNT (BIT_COUNT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clearing  (clearing),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_present (m_present)
    );

endmodule

`default_nettype wire
